// File: rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

   // pipeline depth and stage positions
   localparam int Stages   = 7;
   localparam int StgQuot  = 0;   // hue / 60
   localparam int StgRem   = 1;   // remainder and sextant quotient
   localparam int StgBase  = 2;   // base color
   localparam int StgLift  = 3;   // (255 - x) * lift
   localparam int StgAdd   = 4;   // x + lift / 100
   localparam int StgDim   = 5;   // t * v
   localparam int StgOut   = 6;   // / 100

   localparam logic [7:0] ChanMax = 8'd255;
   localparam logic [7:0] PctMax  = 8'd100;

   // reciprocal multipliers, exact over the value ranges they see
   localparam logic [16:0] Div60Mul    = 17'd69906;   // ceil(2^22 / 60)
   localparam int          Div60Shift  = 22;
   localparam logic [11:0] Div6Mul     = 12'd2731;    // ceil(2^14 / 6)
   localparam int          Div6Shift   = 14;
   localparam logic [15:0] Div100Mul   = 16'd41944;   // ceil(2^22 / 100)
   localparam int          Div100Shift = 22;

   typedef enum logic [2:0] {
      SEXT_RED_YEL = 3'd0,
      SEXT_YEL_GRN = 3'd1,
      SEXT_GRN_CYN = 3'd2,
      SEXT_CYN_BLU = 3'd3,
      SEXT_BLU_MAG = 3'd4,
      SEXT_MAG_RED = 3'd5
   } sextant_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [Stages-1:0] en;   // stage register load enables
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/hsv_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// hsv_pipe_ctrl
// Valid bits and stall propagation for the pixel pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_pipe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hsv_pkg::pipe_ctrl_type     ctrl
);

   logic [hsv_pkg::Stages-1:0] valid_ff;
   logic [hsv_pkg::Stages-1:0] valid_in;
   logic [hsv_pkg::Stages-1:0] ready;

   // a stage may load when it is empty or its word moves on
   always_comb begin
      ready[hsv_pkg::Stages-1] = !valid_ff[hsv_pkg::Stages-1] || !rsp_stall;
      for (int i = hsv_pkg::Stages-2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < hsv_pkg::Stages; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en   = ready;
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[hsv_pkg::Stages-1];

endmodule

`default_nettype wire

// File: rtl/hsv_hue_sextant.sv
// ----------------------------------------------------------------------------
// hsv_hue_sextant
// Hue reduction, sextant pick and ramp; yields the unlifted base color.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_hue_sextant (
   input  wire logic                    clock,
   input  wire hsv_pkg::pipe_ctrl_type  ctrl,
   input  wire logic [15:0]             hue,
   input  wire logic [7:0]              saturation,
   input  wire logic [7:0]              brightness,
   output hsv_pkg::rgb_type             base_rgb,
   output logic [6:0]                   lift,
   output logic [6:0]                   level
);

   // stage 1: hue / 60, clamp percents
   logic [32:0] q60_prod;
   logic [6:0]  lift_in;
   logic [6:0]  level_in;
   logic [15:0] s1_hue_ff;
   logic [10:0] s1_q60_ff;
   logic [6:0]  s1_lift_ff;
   logic [6:0]  s1_level_ff;

   assign q60_prod = 33'(hue) * 33'(hsv_pkg::Div60Mul);
   assign lift_in  = (saturation > hsv_pkg::PctMax) ? 7'd0
                                                    : 7'(hsv_pkg::PctMax - saturation);
   assign level_in = (brightness > hsv_pkg::PctMax) ? 7'(hsv_pkg::PctMax)
                                                    : brightness[6:0];

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgQuot]) begin
         s1_hue_ff   <= hue;
         s1_q60_ff   <= q60_prod[hsv_pkg::Div60Shift +: 11];
         s1_lift_ff  <= lift_in;
         s1_level_ff <= level_in;
      end
   end

   // stage 2: remainder mod 60, and (hue / 60) / 6
   logic [15:0] q60x60;
   logic [15:0] rem_full;
   logic [22:0] q6_prod;
   logic [5:0]  s2_rem_ff;
   logic [10:0] s2_q60_ff;
   logic [8:0]  s2_q6_ff;
   logic [6:0]  s2_lift_ff;
   logic [6:0]  s2_level_ff;

   assign q60x60   = {5'd0, s1_q60_ff} * 16'd60;
   assign rem_full = s1_hue_ff - q60x60;
   assign q6_prod  = 23'(s1_q60_ff) * 23'(hsv_pkg::Div6Mul);

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgRem]) begin
         s2_rem_ff   <= rem_full[5:0];
         s2_q60_ff   <= s1_q60_ff;
         s2_q6_ff    <= q6_prod[hsv_pkg::Div6Shift +: 9];
         s2_lift_ff  <= s1_lift_ff;
         s2_level_ff <= s1_level_ff;
      end
   end

   // stage 3: sextant, ramp, base color
   logic [10:0]          idx_full;
   logic [2:0]           idx;
   hsv_pkg::sextant_type sext;
   logic [9:0]           ramp_prod;
   logic [7:0]           ramp;
   hsv_pkg::rgb_type     rgb_in;
   hsv_pkg::rgb_type     s3_rgb_ff;
   logic [6:0]           s3_lift_ff;
   logic [6:0]           s3_level_ff;

   assign idx_full  = s2_q60_ff - ({2'd0, s2_q6_ff} * 11'd6);
   assign idx       = idx_full[2:0];
   // upper bounds are inclusive: an exact multiple of 60 stays in the lower sextant
   assign sext      = hsv_pkg::sextant_type'((s2_rem_ff == 6'd0 && idx != 3'd0)
                                             ? idx - 3'd1 : idx);
   assign ramp_prod = {4'd0, s2_rem_ff} * 10'd17;   // 425/100 = 17/4
   assign ramp      = ramp_prod[9:2];

   always_comb begin
      case (sext)
         hsv_pkg::SEXT_RED_YEL: rgb_in = '{hsv_pkg::ChanMax, ramp, 8'd0};
         hsv_pkg::SEXT_YEL_GRN: rgb_in = '{hsv_pkg::ChanMax - ramp, hsv_pkg::ChanMax, 8'd0};
         hsv_pkg::SEXT_GRN_CYN: rgb_in = '{8'd0, hsv_pkg::ChanMax, ramp};
         hsv_pkg::SEXT_CYN_BLU: rgb_in = '{8'd0, hsv_pkg::ChanMax - ramp, hsv_pkg::ChanMax};
         hsv_pkg::SEXT_BLU_MAG: rgb_in = '{ramp, 8'd0, hsv_pkg::ChanMax};
         hsv_pkg::SEXT_MAG_RED: rgb_in = '{hsv_pkg::ChanMax, 8'd0, hsv_pkg::ChanMax - ramp};
         default:               rgb_in = '{8'd0, 8'd0, 8'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgBase]) begin
         s3_rgb_ff   <= rgb_in;
         s3_lift_ff  <= s2_lift_ff;
         s3_level_ff <= s2_level_ff;
      end
   end

   assign base_rgb = s3_rgb_ff;
   assign lift     = s3_lift_ff;
   assign level    = s3_level_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_lift_scale.sv
// ----------------------------------------------------------------------------
// hsv_lift_scale
// One color channel: lift toward full scale by saturation, then dim by value.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_lift_scale (
   input  wire logic                    clock,
   input  wire hsv_pkg::pipe_ctrl_type  ctrl,
   input  wire logic [7:0]              chan_in,
   input  wire logic [6:0]              lift,
   input  wire logic [6:0]              level,
   output logic [7:0]                   chan_out
);

   // stage 4: (255 - x) * lift
   logic [7:0]  headroom;
   logic [14:0] s4_prod_ff;
   logic [7:0]  s4_chan_ff;
   logic [6:0]  s4_level_ff;

   assign headroom = hsv_pkg::ChanMax - chan_in;

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgLift]) begin
         s4_prod_ff  <= 15'(headroom) * 15'(lift);
         s4_chan_ff  <= chan_in;
         s4_level_ff <= level;
      end
   end

   // stage 5: x + prod / 100
   logic [30:0] lift_div;
   logic [8:0]  lifted;
   logic [7:0]  s5_chan_ff;
   logic [6:0]  s5_level_ff;

   assign lift_div = 31'(s4_prod_ff) * 31'(hsv_pkg::Div100Mul);
   assign lifted   = {1'b0, s4_chan_ff} + lift_div[hsv_pkg::Div100Shift +: 9];

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgAdd]) begin
         s5_chan_ff  <= lifted[7:0];
         s5_level_ff <= s4_level_ff;
      end
   end

   // stage 6: t * v
   logic [14:0] s6_prod_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgDim]) begin
         s6_prod_ff <= 15'(s5_chan_ff) * 15'(s5_level_ff);
      end
   end

   // stage 7: / 100
   logic [30:0] dim_div;
   logic [7:0]  s7_chan_ff;

   assign dim_div = 31'(s6_prod_ff) * 31'(hsv_pkg::Div100Mul);

   always_ff @(posedge clock) begin
      if (ctrl.en[hsv_pkg::StgOut]) begin
         s7_chan_ff <= dim_div[hsv_pkg::Div100Shift +: 8];
      end
   end

   assign chan_out = s7_chan_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_pixel_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter
// Integer HSV (hue in degrees, percent saturation and value) to 8-bit RGB.
// ----------------------------------------------------------------------------
// Request channel: req_valid / req_stall with req_hue, req_saturation and
// req_brightness. Response channel: rsp_valid / rsp_stall with rsp_red,
// rsp_green and rsp_blue. A word moves when valid is high and stall is low.
// One response word per request word, in order.
// Datapath: a request word passes through seven register stages (hue divide,
// remainder, base color, lift multiply, lift divide, dim multiply, dim divide),
// each about one multiply deep, before rsp_valid rises with its response word.
// Throughput: one pixel per cycle while the response side takes words.
// When rsp_stall is high, stages fill up behind the waiting word; empty
// stages still take words, and req_stall rises only once every stage holds
// one. Nothing is dropped or duplicated.
// Reset (synchronous, active high) clears all valid bits; the data registers
// are not reset, and there is no configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);

   hsv_pkg::pipe_ctrl_type ctrl;
   hsv_pkg::rgb_type       base_rgb;
   logic [6:0]             lift;
   logic [6:0]             level;

   hsv_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   hsv_hue_sextant u_hue (
      .clock      (clock),
      .ctrl       (ctrl),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .base_rgb   (base_rgb),
      .lift       (lift),
      .level      (level)
   );

   hsv_lift_scale u_red (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (base_rgb.red),
      .lift     (lift),
      .level    (level),
      .chan_out (rsp_red)
   );

   hsv_lift_scale u_green (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (base_rgb.green),
      .lift     (lift),
      .level    (level),
      .chan_out (rsp_green)
   );

   hsv_lift_scale u_blue (
      .clock    (clock),
      .ctrl     (ctrl),
      .chan_in  (base_rgb.blue),
      .lift     (lift),
      .level    (level),
      .chan_out (rsp_blue)
   );

endmodule

`default_nettype wire

// File: dv/hsv_to_rgb_pixel_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_checker
// Watches both channels of the HSV to RGB converter, computes the color each
// accepted request word should produce and compares every response word,
// in order, against it. Reports mismatch and outstanding counts to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_converter_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_red,
   input  wire logic [7:0]  rsp_green,
   input  wire logic [7:0]  rsp_blue,
   output int               mismatch_count,
   output int               pixels_outstanding
);

   hsv_pkg::rgb_type pending_pixels[$];
   int               fail_total = 0;

   // desaturate toward full scale, then dim; divisions truncate
   function automatic logic [7:0] lift_and_dim(int unsigned x, int unsigned lift,
                                               int unsigned dim);
      int unsigned y;
      y = x + ((hsv_pkg::ChanMax - x) * lift) / hsv_pkg::PctMax;
      return 8'((y * dim) / hsv_pkg::PctMax);
   endfunction

   function automatic hsv_pkg::rgb_type pixel_from_hsv(logic [15:0] hue, logic [7:0] sat,
                                                       logic [7:0] bri);
      int unsigned          hr;
      int unsigned          ramp;
      int unsigned          lift;
      int unsigned          dim;
      int unsigned          r, g, b;
      hsv_pkg::sextant_type sext;
      hsv_pkg::rgb_type     px;
      hr   = hue;
      hr   = hr % 360;
      ramp = (425 * (hr % 60)) / 100;
      // upper bounds are inclusive, so boundary hues stay in the lower sextant
      if (hr <= 60)       sext = hsv_pkg::SEXT_RED_YEL;
      else if (hr <= 120) sext = hsv_pkg::SEXT_YEL_GRN;
      else if (hr <= 180) sext = hsv_pkg::SEXT_GRN_CYN;
      else if (hr <= 240) sext = hsv_pkg::SEXT_CYN_BLU;
      else if (hr <= 300) sext = hsv_pkg::SEXT_BLU_MAG;
      else                sext = hsv_pkg::SEXT_MAG_RED;
      case (sext)
         hsv_pkg::SEXT_RED_YEL: begin
            r = hsv_pkg::ChanMax;        g = ramp;                    b = 0;
         end
         hsv_pkg::SEXT_YEL_GRN: begin
            r = hsv_pkg::ChanMax - ramp; g = hsv_pkg::ChanMax;        b = 0;
         end
         hsv_pkg::SEXT_GRN_CYN: begin
            r = 0;                       g = hsv_pkg::ChanMax;        b = ramp;
         end
         hsv_pkg::SEXT_CYN_BLU: begin
            r = 0;                       g = hsv_pkg::ChanMax - ramp; b = hsv_pkg::ChanMax;
         end
         hsv_pkg::SEXT_BLU_MAG: begin
            r = ramp;                    g = 0;                       b = hsv_pkg::ChanMax;
         end
         default: begin
            r = hsv_pkg::ChanMax;        g = 0;                       b = hsv_pkg::ChanMax - ramp;
         end
      endcase
      lift = (sat > hsv_pkg::PctMax) ? 0 : hsv_pkg::PctMax - sat;
      dim  = (bri > hsv_pkg::PctMax) ? hsv_pkg::PctMax : bri;
      px.red   = lift_and_dim(r, lift, dim);
      px.green = lift_and_dim(g, lift, dim);
      px.blue  = lift_and_dim(b, lift, dim);
      return px;
   endfunction

   always @(posedge clock) begin
      hsv_pkg::rgb_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected word r=%0d g=%0d b=%0d", $realtime,
                           rsp_red, rsp_green, rsp_blue);
            end else begin
               want = pending_pixels.pop_front();
               if (want.red !== rsp_red || want.green !== rsp_green ||
                   want.blue !== rsp_blue) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp_red, rsp_green, rsp_blue);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_pixels.push_back(pixel_from_hsv(req_hue, req_saturation,
                                                    req_brightness));
      end
      mismatch_count     <= fail_total;
      pixels_outstanding <= pending_pixels.size();
   end

endmodule

`default_nettype wire

// File: dv/hsv_to_rgb_pixel_converter_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_tb
// Drives the converter with directed corner pixels (sextant edges, hue wrap,
// saturation and brightness limits) and then random pixels under random
// request gaps and response stalls, including one long response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_converter_tb;

   localparam int RandomPixels = 630;
   localparam int CalmTail     = 50;
   localparam int HoldCycles   = 80;
   localparam int IdleLimit    = 1000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [15:0] req_hue        = '0;
   logic [7:0]  req_saturation = '0;
   logic [7:0]  req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   int mismatch_count;
   int pixels_outstanding;
   int idle_cycles = 0;
   bit calm        = 1'b0;
   bit squeeze     = 1'b0;
   bit squeeze_done = 1'b0;

   always #4 clock = ~clock;

   hsv_to_rgb_pixel_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   hsv_to_rgb_pixel_converter_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_hue            (req_hue),
      .req_saturation     (req_saturation),
      .req_brightness     (req_brightness),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .mismatch_count     (mismatch_count),
      .pixels_outstanding (pixels_outstanding)
   );

   // watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stall bursts, one long hold-off, none at the end
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            squeeze_done = 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                             input logic [7:0] bri);
      bit gap;
      gap = !calm && !(squeeze && !squeeze_done) && ($urandom_range(0, 3) == 0);
      if (gap) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_percent();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 100));
   endfunction

   initial begin
      logic [15:0] hue;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sextant edges and midpoints at full color
      send_pixel(16'd0,   8'd100, 8'd100);
      send_pixel(16'd60,  8'd100, 8'd100);
      send_pixel(16'd120, 8'd100, 8'd100);
      send_pixel(16'd180, 8'd100, 8'd100);
      send_pixel(16'd240, 8'd100, 8'd100);
      send_pixel(16'd300, 8'd100, 8'd100);
      send_pixel(16'd30,  8'd100, 8'd100);
      send_pixel(16'd90,  8'd100, 8'd100);
      send_pixel(16'd150, 8'd100, 8'd100);
      send_pixel(16'd210, 8'd100, 8'd100);
      send_pixel(16'd270, 8'd100, 8'd100);
      send_pixel(16'd330, 8'd100, 8'd100);
      send_pixel(16'd59,  8'd100, 8'd100);
      send_pixel(16'd301, 8'd100, 8'd100);
      send_pixel(16'd359, 8'd100, 8'd100);
      // hue wrap
      send_pixel(16'd360,   8'd100, 8'd100);
      send_pixel(16'd65535, 8'd100, 8'd100);
      // saturation and brightness limits
      send_pixel(16'd45,    8'd0,   8'd100);
      send_pixel(16'd200,   8'd50,  8'd50);
      send_pixel(16'd100,   8'd101, 8'd101);
      send_pixel(16'd250,   8'd255, 8'd255);
      send_pixel(16'd10,    8'd100, 8'd0);
      send_pixel(16'd65535, 8'd255, 8'd0);
      send_pixel(16'd0,     8'd0,   8'd255);

      squeeze = 1'b1;
      for (int i = 0; i < RandomPixels; i++) begin
         if (i == RandomPixels - CalmTail) calm = 1'b1;
         case ($urandom_range(0, 3))
            0: hue = 16'($urandom);
            1: hue = 16'($urandom_range(0, 359));
            // around a sextant edge, possibly after several full turns
            2: hue = 16'(60 * $urandom_range(1, 6) - 1 + $urandom_range(0, 2)
                         + 360 * $urandom_range(0, 180));
            default: hue = 16'(16'hFFFF - $urandom_range(0, 400));
         endcase
         send_pixel(hue, pick_percent(), pick_percent());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (hsv_pkg::Stages + 5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/hsv_pkg.sv
rtl/hsv_pipe_ctrl.sv
rtl/hsv_hue_sextant.sv
rtl/hsv_lift_scale.sv
rtl/hsv_to_rgb_pixel_converter.sv
dv/hsv_to_rgb_pixel_converter_checker.sv
dv/hsv_to_rgb_pixel_converter_tb.sv
